// ----- rtl/sbc_pkg.sv -----
`timescale 1ns / 1ps
// sbc_pkg: item types, function, outcome, condition and register codes
// for the slab cell boundary crossing core. no dependencies.
package sbc_pkg;

  localparam int APB_AW = 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CROSS = 1'b1;

  localparam logic [1:0] COND_ABSORB = 2'd0;
  localparam logic [1:0] COND_MIRROR = 2'd1;
  localparam logic [1:0] COND_WHITE  = 2'd2;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_CELLS = 2'd2;

  localparam logic [2:0] OC_INNER     = 3'd0;
  localparam logic [2:0] OC_REFLECT   = 3'd1;
  localparam logic [2:0] OC_WHITE     = 3'd2;
  localparam logic [2:0] OC_ABSORB    = 3'd3;
  localparam logic [2:0] OC_ZERO_DIR  = 3'd4;
  localparam logic [2:0] OC_NOT_FOUND = 3'd5;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic               func;
    logic [4:0]         edge_index;
    logic [31:0]        edge_value;
    logic [31:0]        position;
    logic signed [15:0] direction;
    logic [31:0]        path_length;
    logic [14:0]        random_cosine;
  } sbc_req_t;

  typedef struct packed {
    logic [31:0]        new_position;
    logic signed [15:0] new_direction;
    logic [3:0]         new_cell;
    logic [2:0]         outcome;
  } sbc_rsp_t;

endpackage

// ----- rtl/slab_cell_boundary_crossing_core.sv -----
`timescale 1ns / 1ps
// slab_cell_boundary_crossing_core: edge table, flight end point and cell
// lookup sequencer for a one-dimensional slab. depends on sbc_pkg.
//
// usage: req carries one item per accept (req_valid high, req_stall low).
// a load item (func 0) writes one cell edge and is taken only
// while the core is idle; it gives no result. a crossing item (func 1)
// gives exactly one rsp item. req_stall is high while a crossing item is
// in work. the apb port sets the face conditions and the cell count; the
// user is to write it only while the core is idle, as the core itself
// does not enforce this. pready is tied high. a zero direction item
// goes from accept straight to the done step. for other crossings the
// edge table's single read port sets the pace: each cell lookup walks
// the edges one per cycle through one shared compare unit, and a
// crossing needs up to two lookups. the multiply and the end point add
// are registered steps of their own; one nudge adder serves both nudges.
// the output register holds a finished item while rsp_stall is high; a new
// crossing item is accepted meanwhile and waits at its last step.
// reset: synchronous, clears control state and sets the conditions to
// absorb and the cell count to 16. the edge table is not cleared.
module slab_cell_boundary_crossing_core import sbc_pkg::*; #(
  parameter int MAX_CELLS = 16,
  parameter int NUDGE     = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sbc_req_t          req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output sbc_rsp_t          rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW   = $clog2(MAX_CELLS + 1);
  localparam int KW   = $clog2(MAX_CELLS + 2);
  localparam int CMPW = (AW > 5) ? AW : 5;
  localparam logic [33:0] NUDGE34 = 34'(NUDGE);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_END   = 8'b0000_0100,
    S_RIGHT = 8'b0000_1000,
    S_TEST  = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_NUDGE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } sbc_state_t;

  sbc_state_t state;

  logic [1:0] left_condition;
  logic [1:0] right_condition;
  logic [4:0] cells_in_use;

  logic [31:0] cell_edges [MAX_CELLS + 1];
  logic [31:0] rdata;
  logic [AW-1:0] rd_addr;

  logic [31:0]        pos_q;
  logic signed [15:0] dir_q;
  logic [31:0]        len_q;
  logic [14:0]        rnd_q;
  logic [47:0]        prod;
  logic signed [35:0] end_x;
  logic [31:0]        left_q;
  logic [31:0]        right_q;
  logic [31:0]        scan_x;
  logic [31:0]        prev;
  logic [31:0]        lo_q;
  logic [31:0]        hi_q;
  logic [KW-1:0]      scan_k;
  logic               scan_final;

  logic [31:0]        res_position;
  logic signed [15:0] res_direction;
  logic [3:0]         res_cell;
  logic [2:0]         res_outcome;

  // cell count clamped to 1..MAX_CELLS
  logic [CMPW-1:0] ciu_ext;
  logic [AW-1:0]   n_cells;
  always_comb begin
    ciu_ext = CMPW'(cells_in_use);
    if (ciu_ext == '0) begin
      n_cells = AW'(1);
    end else if (ciu_ext > CMPW'(MAX_CELLS)) begin
      n_cells = AW'(MAX_CELLS);
    end else begin
      n_cells = AW'(ciu_ext);
    end
  end

  logic rightward;
  assign rightward = !dir_q[15];

  logic [15:0] dir_mag;
  assign dir_mag = dir_q[15] ? 16'(-dir_q) : 16'(dir_q);

  // end point against the outer faces
  logic outside;
  logic [1:0] face_cond;
  assign outside = (end_x < $signed({4'b0, left_q})) || (end_x > $signed({4'b0, right_q}));
  assign face_cond = rightward ? right_condition : left_condition;

  // shared nudge adder: face nudge in S_TEST, edge nudge in S_NUDGE
  logic [31:0]        nudge_base;
  logic               nudge_sub;
  logic signed [33:0] nudge_sum;
  logic [31:0]        nudge_pos;
  always_comb begin
    if (state == S_TEST) begin
      nudge_base = rightward ? right_q : left_q;
      nudge_sub  = rightward;
    end else begin
      nudge_base = rightward ? hi_q : lo_q;
      nudge_sub  = !rightward;
    end
    nudge_sum = nudge_sub ? $signed({2'b0, nudge_base} - NUDGE34)
                          : $signed({2'b0, nudge_base} + NUDGE34);
    if (nudge_sum[33]) begin
      nudge_pos = '0;
    end else if (nudge_sum[32]) begin
      nudge_pos = '1;
    end else begin
      nudge_pos = nudge_sum[31:0];
    end
  end

  // reflected and re-emitted cosines
  logic signed [16:0] neg_dir;
  logic signed [15:0] mirror_dir;
  logic signed [15:0] white_dir;
  always_comb begin
    neg_dir = -{dir_q[15], dir_q};
    if (neg_dir > 17'(ONE_Q14)) begin
      mirror_dir = ONE_Q14;
    end else if (neg_dir < -17'(ONE_Q14)) begin
      mirror_dir = -ONE_Q14;
    end else begin
      mirror_dir = 16'(neg_dir);
    end
    white_dir = rightward ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
  end

  // shared scan compare: edge k-2 in prev, edge k-1 in rdata
  logic          scan_hit;
  logic          scan_last;
  logic          scan_done;
  logic          scan_found;
  logic [AW-1:0] scan_c;
  logic          no_neighbor;
  always_comb begin
    scan_hit   = (scan_k >= KW'(2)) && (scan_x >= prev) && (scan_x < rdata);
    scan_last  = scan_k == (KW'(n_cells) + KW'(1));
    scan_done  = scan_hit || scan_last;
    scan_found = scan_hit || (scan_last && (scan_x == rdata));
    scan_c     = AW'(scan_k - KW'(2));
    no_neighbor = rightward ? (KW'(scan_k - KW'(1)) >= KW'(n_cells)) : (scan_k == KW'(2));
  end

  always_comb begin
    unique case (state)
      S_MUL:   rd_addr = '0;
      S_END:   rd_addr = n_cells;
      S_SCAN:  rd_addr = (scan_k <= KW'(n_cells)) ? AW'(scan_k) : n_cells;
      default: rd_addr = '0;
    endcase
  end

  logic req_accept;
  assign req_stall  = state != S_IDLE;
  assign req_accept = req_valid && !req_stall;

  // edge table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req_accept && req.func == FUNC_LOAD && 32'(req.edge_index) <= MAX_CELLS) begin
      cell_edges[AW'(req.edge_index)] <= req.edge_value;
    end
    rdata <= cell_edges[rd_addr];
  end

  // configuration port
  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_condition  <= COND_ABSORB;
      right_condition <= COND_ABSORB;
      cells_in_use    <= 5'd16;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LEFT:  left_condition  <= pwdata[1:0];
        REG_RIGHT: right_condition <= pwdata[1:0];
        REG_CELLS: cells_in_use    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEFT:  prdata = 32'(left_condition);
      REG_RIGHT: prdata = 32'(right_condition);
      REG_CELLS: prdata = 32'(cells_in_use);
      default:   prdata = '0;
    endcase
  end

  // output register: loaded from a finished item, cleared once taken
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_accept && req.func == FUNC_CROSS) begin
            pos_q <= req.position;
            dir_q <= req.direction;
            len_q <= req.path_length;
            rnd_q <= (req.random_cosine > 15'(ONE_Q14)) ? 15'(ONE_Q14) : req.random_cosine;
            if (req.direction == '0) begin
              res_position  <= req.position;
              res_direction <= '0;
              res_cell      <= '0;
              res_outcome   <= OC_ZERO_DIR;
              state         <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= 48'(dir_mag) * 48'(len_q);
          state <= S_END;
        end
        S_END: begin
          left_q <= rdata;
          end_x  <= rightward ? $signed({4'b0, pos_q} + {2'b0, prod[47:14]})
                              : $signed({4'b0, pos_q} - {2'b0, prod[47:14]});
          state  <= S_RIGHT;
        end
        S_RIGHT: begin
          right_q <= rdata;
          state   <= S_TEST;
        end
        S_TEST: begin
          scan_k <= '0;
          if (outside) begin
            if (face_cond == COND_MIRROR || face_cond == COND_WHITE) begin
              scan_x        <= nudge_pos;
              res_position  <= nudge_pos;
              res_direction <= (face_cond == COND_MIRROR) ? mirror_dir : white_dir;
              res_outcome   <= (face_cond == COND_MIRROR) ? OC_REFLECT : OC_WHITE;
              scan_final    <= 1'b1;
              state         <= S_SCAN;
            end else begin
              res_position  <= pos_q;
              res_direction <= dir_q;
              res_cell      <= '0;
              res_outcome   <= OC_ABSORB;
              state         <= S_DONE;
            end
          end else begin
            scan_x     <= pos_q;
            scan_final <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev   <= rdata;
          scan_k <= scan_k + KW'(1);
          if (scan_done) begin
            if (scan_final) begin
              res_cell <= scan_found ? 4'(scan_c) : '0;
              state    <= S_DONE;
            end else if (!scan_found || no_neighbor) begin
              res_position  <= pos_q;
              res_direction <= dir_q;
              res_cell      <= '0;
              res_outcome   <= OC_NOT_FOUND;
              state         <= S_DONE;
            end else begin
              lo_q  <= prev;
              hi_q  <= rdata;
              state <= S_NUDGE;
            end
          end
        end
        S_NUDGE: begin
          scan_x        <= nudge_pos;
          res_position  <= nudge_pos;
          res_direction <= dir_q;
          res_outcome   <= OC_INNER;
          scan_final    <= 1'b1;
          scan_k        <= '0;
          state         <= S_SCAN;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.new_position  <= res_position;
            rsp.new_direction <= res_direction;
            rsp.new_cell      <= res_cell;
            rsp.outcome       <= res_outcome;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // scan never walks past the face edge
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_k <= (KW'(n_cells) + KW'(1)))
    else $error("cell scan ran past the last edge");

  // a nonzero crossing item starts at the multiply step
  assert property (@(posedge clk) disable iff (rst)
    req_accept && req.func == FUNC_CROSS && req.direction != '0 |=> state == S_MUL)
    else $error("crossing item did not start the multiply");

  // finished item reaches the output register once the slot is free
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !(rsp_valid && rsp_stall) |=> rsp_valid && state == S_IDLE)
    else $error("finished item not moved to the output");

  // pass-through outcomes carry cell zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome == OC_ABSORB || rsp.outcome == OC_NOT_FOUND ||
                  rsp.outcome == OC_ZERO_DIR) |-> rsp.new_cell == '0)
    else $error("pass-through item with nonzero cell");
`endif

endmodule
